// ===== hdl/tef_pkg.sv =====
package tef_pkg;

    typedef enum logic [2:0] {
        MODE_TEXT    = 3'd0,
        MODE_ESC     = 3'd1,
        MODE_CSI     = 3'd2,
        MODE_OSC     = 3'd3,
        MODE_OSC_ESC = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ACT_PUSH  = 2'd0,
        ACT_BACK  = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    typedef struct packed {
        action_t    action;
        logic [7:0] out_char;
    } item_t;

    // Depth of the queue between the parser and the output stage
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic [7:0] CH_BEL    = 8'h07;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_FINLO  = 8'h40;
    localparam logic [7:0] CH_J      = 8'h4A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_C      = 8'h63;
    localparam logic [7:0] CH_H      = 8'h68;
    localparam logic [7:0] CH_L      = 8'h6C;
    localparam logic [7:0] CH_FINHI  = 8'h7E;
    localparam logic [7:0] CH_DEL    = 8'h7F;

    localparam logic [15:0] PV_ALT_47   = 16'd47;
    localparam logic [15:0] PV_ALT_1047 = 16'd1047;
    localparam logic [15:0] PV_ALT_1049 = 16'd1049;
    localparam logic [15:0] PV_ED_ALL   = 16'd2;
    localparam logic [15:0] PV_ED_SCRL  = 16'd3;
    localparam logic [15:0] PV_MAX      = 16'hFFFF;

endpackage

// ===== hdl/terminal_escape_filter_top.sv =====
// Terminal escape filter: takes one terminal byte per request on the s_ channel and
// delivers at most one screen action per byte on the m_ channel (push character,
// backspace, clear screen). A byte is accepted every cycle while the four-entry action
// queue has room, so the sustained rate is one byte per clock; a byte that yields an
// action is written into the queue at its accepting edge and then loaded into the
// registered output stage, which raises m_valid. The parser state (text, escape,
// CSI, OSC, OSC-escape) and the first CSI parameter are updated in the cycle the byte
// is accepted, with a single multiply-by-ten add per digit. When the m_ side stalls,
// actions collect in the queue and s_ready drops only once it is full.
module terminal_escape_filter_top #(
    parameter int PARAM_BUF_BYTES = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_action,
    output logic [7:0] m_out_char
);

    logic           take;
    logic           push;
    tef_pkg::item_t push_item;
    logic           q_full, q_nonempty, q_pop;
    tef_pkg::item_t q_head;

    // Accept a request whenever the queue can hold its action
    assign s_ready = !q_full;
    assign take    = s_valid && s_ready;

    // Front: decode the byte and advance the parser
    tef_front #(
        .PARAM_BUF_BYTES(PARAM_BUF_BYTES)
    ) u_front (
        .aclk   (aclk),
        .aresetn(aresetn),
        .take   (take),
        .in_byte(s_in_byte),
        .push   (push),
        .item   (push_item)
    );

    // Queue: hold actions until the output side takes them
    tef_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_item(push_item),
        .full     (q_full),
        .pop      (q_pop),
        .nonempty (q_nonempty),
        .head     (q_head)
    );

    // Back: registered output stage
    tef_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_nonempty(q_nonempty),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_action  (m_action),
        .m_out_char(m_out_char)
    );

endmodule

// ===== hdl/tef_front.sv =====
module tef_front #(
    parameter int PARAM_BUF_BYTES = 64
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           take,
    input  logic [7:0]     in_byte,
    output logic           push,
    output tef_pkg::item_t item
);

    localparam int CntW = (PARAM_BUF_BYTES > 2) ? $clog2(PARAM_BUF_BYTES) : 1;
    localparam logic [CntW-1:0] CntLast = CntW'(PARAM_BUF_BYTES - 1);

    tef_pkg::mode_t mode_reg, mode_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            quest_reg, quest_next;
    logic            seen_reg, seen_next;
    logic            ended_reg, ended_next;
    logic [15:0]     val_reg, val_next;

    logic        is_digit, is_final, is_prefix, room, csi_clr;
    logic [19:0] mac;

    assign is_digit  = (in_byte >= tef_pkg::CH_ZERO) && (in_byte <= tef_pkg::CH_NINE);
    assign is_final  = (in_byte >= tef_pkg::CH_FINLO) && (in_byte <= tef_pkg::CH_FINHI);
    assign is_prefix = (cnt_reg == '0) &&
                       (in_byte == tef_pkg::CH_QMARK || in_byte == tef_pkg::CH_GT ||
                        in_byte == tef_pkg::CH_LT || in_byte == tef_pkg::CH_EQ);
    assign room      = (cnt_reg != CntLast);
    // value*10 + digit as (v<<3) + (v<<1) + d
    assign mac = {1'b0, val_reg, 3'b000} + {3'b000, val_reg, 1'b0}
               + {16'd0, 4'(in_byte - tef_pkg::CH_ZERO)};

    always_comb begin
        csi_clr = 1'b0;
        if (in_byte == tef_pkg::CH_J) begin
            csi_clr = seen_reg && (val_reg == tef_pkg::PV_ED_ALL ||
                                   val_reg == tef_pkg::PV_ED_SCRL);
        end else if (in_byte == tef_pkg::CH_H || in_byte == tef_pkg::CH_L) begin
            csi_clr = (cnt_reg != '0) && quest_reg && seen_reg &&
                      (val_reg == tef_pkg::PV_ALT_47 || val_reg == tef_pkg::PV_ALT_1047 ||
                       val_reg == tef_pkg::PV_ALT_1049);
        end
    end

    // Next parser mode
    always_comb begin
        case (mode_reg)
            tef_pkg::MODE_ESC: begin
                if (in_byte == tef_pkg::CH_LBRACK) mode_next = tef_pkg::MODE_CSI;
                else if (in_byte == tef_pkg::CH_RBRACK) mode_next = tef_pkg::MODE_OSC;
                else mode_next = tef_pkg::MODE_TEXT;
            end
            tef_pkg::MODE_CSI: begin
                mode_next = is_final ? tef_pkg::MODE_TEXT : tef_pkg::MODE_CSI;
            end
            tef_pkg::MODE_OSC: begin
                if (in_byte == tef_pkg::CH_BEL) mode_next = tef_pkg::MODE_TEXT;
                else if (in_byte == tef_pkg::CH_ESC) mode_next = tef_pkg::MODE_OSC_ESC;
                else mode_next = tef_pkg::MODE_OSC;
            end
            tef_pkg::MODE_OSC_ESC: begin
                mode_next = (in_byte == tef_pkg::CH_BSLASH) ? tef_pkg::MODE_TEXT
                                                            : tef_pkg::MODE_OSC;
            end
            default: begin
                mode_next = (in_byte == tef_pkg::CH_ESC) ? tef_pkg::MODE_ESC
                                                         : tef_pkg::MODE_TEXT;
            end
        endcase
    end

    // Action and parameter tracking
    always_comb begin
        push          = 1'b0;
        item.action   = tef_pkg::ACT_PUSH;
        item.out_char = 8'd0;
        cnt_next      = cnt_reg;
        quest_next    = quest_reg;
        seen_next     = seen_reg;
        ended_next    = ended_reg;
        val_next      = val_reg;
        case (mode_reg)
            tef_pkg::MODE_ESC: begin
                if (in_byte == tef_pkg::CH_LBRACK) begin
                    cnt_next   = '0;
                    quest_next = 1'b0;
                    seen_next  = 1'b0;
                    ended_next = 1'b0;
                    val_next   = '0;
                end else if (in_byte == tef_pkg::CH_C) begin
                    push        = take;
                    item.action = tef_pkg::ACT_CLEAR;
                end
            end
            tef_pkg::MODE_CSI: begin
                if (is_final) begin
                    push        = take && csi_clr;
                    item.action = tef_pkg::ACT_CLEAR;
                    cnt_next    = '0;
                    quest_next  = 1'b0;
                    seen_next   = 1'b0;
                    ended_next  = 1'b0;
                    val_next    = '0;
                end else if (room) begin
                    cnt_next = cnt_reg + 1'b1;
                    if (is_prefix) begin
                        quest_next = (in_byte == tef_pkg::CH_QMARK);
                    end else if (!ended_reg) begin
                        if (is_digit) begin
                            val_next  = (mac > 20'(tef_pkg::PV_MAX)) ? tef_pkg::PV_MAX
                                                                     : mac[15:0];
                            seen_next = 1'b1;
                        end else begin
                            ended_next = 1'b1;
                        end
                    end
                end
            end
            tef_pkg::MODE_OSC, tef_pkg::MODE_OSC_ESC: begin
                push = 1'b0;
            end
            default: begin
                if (in_byte == tef_pkg::CH_BS || in_byte == tef_pkg::CH_DEL) begin
                    push        = take;
                    item.action = tef_pkg::ACT_BACK;
                end else if (in_byte == tef_pkg::CH_ESC) begin
                    push = 1'b0;
                end else if (in_byte >= tef_pkg::CH_SPACE || in_byte == tef_pkg::CH_LF ||
                             in_byte == tef_pkg::CH_TAB) begin
                    push          = take;
                    item.out_char = in_byte;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= tef_pkg::MODE_TEXT;
            cnt_reg   <= '0;
            quest_reg <= 1'b0;
            seen_reg  <= 1'b0;
            ended_reg <= 1'b0;
            val_reg   <= '0;
        end else if (take) begin
            mode_reg  <= mode_next;
            cnt_reg   <= cnt_next;
            quest_reg <= quest_next;
            seen_reg  <= seen_next;
            ended_reg <= ended_next;
            val_reg   <= val_next;
        end
    end

endmodule

// ===== hdl/tef_queue.sv =====
module tef_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  tef_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           nonempty,
    output tef_pkg::item_t head
);

    tef_pkg::item_t mem_reg [tef_pkg::QUEUE_DEPTH];
    logic [tef_pkg::QPTR_W-1:0] wr_reg, rd_reg;
    logic [tef_pkg::QPTR_W:0]   cnt_reg, cnt_next;
    logic do_push, do_pop;

    assign full     = (cnt_reg == (tef_pkg::QPTR_W+1)'(tef_pkg::QUEUE_DEPTH));
    assign nonempty = (cnt_reg != '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;
    assign head     = mem_reg[rd_reg];

    always_comb begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop) cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push) cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_push) wr_reg <= wr_reg + 1'b1;
            if (do_pop) rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) mem_reg[wr_reg] <= push_item;
    end

    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full) else $error("request pushed into full queue");
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (tef_pkg::QPTR_W+1)'(tef_pkg::QUEUE_DEPTH))
        else $error("queue count out of range");
    a_ptr_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg != (tef_pkg::QPTR_W+1)'(tef_pkg::QUEUE_DEPTH)) |->
        (cnt_reg[tef_pkg::QPTR_W-1:0] == tef_pkg::QPTR_W'(wr_reg - rd_reg)))
        else $error("queue pointers disagree with count");
    a_cnt_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count missed a push");

endmodule

// ===== hdl/tef_back.sv =====
module tef_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_nonempty,
    input  tef_pkg::item_t q_head,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [1:0]     m_action,
    output logic [7:0]     m_out_char
);

    logic           valid_reg;
    tef_pkg::item_t item_reg;
    logic           load;

    // Refill the output register when it is empty or being drained
    assign load  = !valid_reg || m_ready;
    assign q_pop = load && q_nonempty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= q_nonempty;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) item_reg <= q_head;
    end

    assign m_valid    = valid_reg;
    assign m_action   = item_reg.action;
    assign m_out_char = item_reg.out_char;

endmodule
